// ----- rtl/ffa_pkg.sv -----
// Package for the first-fit entry allocator: field widths, request and
// status codes, register map and sequencer types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ffa_pkg;

    // Default sizes of the entry table
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_TAG_BITS    = 16;

    // Field widths on the stream channels
    localparam int REQ_W     = 3;
    localparam int SIDX_W    = 6;
    localparam int LEN_W     = 7;
    localparam int TAG_IN_W  = 16;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Bit offsets inside s_tdata
    localparam int OFS_START = 0;
    localparam int OFS_LEN   = OFS_START + SIDX_W;
    localparam int OFS_OLD   = OFS_LEN + LEN_W;
    localparam int OFS_TAG   = OFS_OLD + LEN_W;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CHECK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MARK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESIZE = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO_LEN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd2;

    // Register map: word index taken from paddr[2]
    localparam int              APB_ADDR_W        = 3;
    localparam int              APB_DATA_W        = 32;
    localparam logic            REG_ENTRIES_IN_USE = 1'b0;
    localparam logic [LEN_W-1:0] ENTRIES_RESET     = 7'd64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_FREE,
        ST_SCAN_FIT,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Step of a request, decides what follows the current pass
    typedef enum logic [1:0] {
        STEP_FINAL,
        STEP_GROW,
        STEP_MOVE_FREE,
        STEP_MOVE_FIT
    } step_t;

endpackage

// ----- rtl/ffa_table.sv -----
// Entry table of the allocator: used flags and owner tags in single-port
// memories with registered read, plus the clearing pass after reset.
// Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_table
    import ffa_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    output logic                           ready,
    input  logic                           rd_en,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
    input  logic                           wr_used,
    input  logic [TAG_BITS-1:0]            wr_tag,
    output logic                           rd_used
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic                used_mem [TABLE_DEPTH];
    logic [TAG_BITS-1:0] owner_mem [TABLE_DEPTH];

    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;
    logic             rd_used_reg;

    // Sweep every entry once after reset
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            if (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    // Write used flags: clearing pass first, then sequencer writes
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            used_mem[clr_idx_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            used_mem[addr] <= wr_used;
        end
    end

    // Record the owner of each marked entry
    always_ff @(posedge clk)
    begin
        if (!clr_busy_reg && wr_en && wr_used)
        begin
            owner_mem[addr] <= wr_tag;
        end
    end

    // Registered read of the used flag
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_used_reg <= used_mem[addr];
        end
    end

    assign rd_used = rd_used_reg;
    assign ready   = !clr_busy_reg;

endmodule

// ----- rtl/first_fit_entry_allocator_unit.sv -----
// Top level of the first-fit entry allocator: APB register, request and
// result streams, and the sequencer that drives one shared scan/write pass.
// Depends on ffa_pkg and ffa_table.
`timescale 1ns / 1ps

// Usage
// - Requests enter on s_tvalid/s_tready: s_tuser carries the request type,
//   s_tdata the run fields. One result per request leaves on m_tvalid/m_tready.
// - Write entries_in_use (APB byte address 0) only while idle; not enforced.
// - One sequencer and one position counter serve every request; the table is
//   touched one entry per cycle through a single memory port.
// - Find and check read entries up to the in-use bound; mark and clear write
//   entries, also stopping at the bound.
// - A resize that moves checks the entries after the run, frees the old run,
//   searches from entry 0 and marks the new run, or restores the old one.
// - One request is in work at a time; s_tready is low until its result is
//   handed to the output register.
// - After reset the used flags are cleared in a pass over every entry;
//   s_tready stays low meanwhile. APB writes are taken as ever.
// - If the receiver stalls, the result holds in the output register and the
//   block may take and work the next request; that one waits for the slot.

module first_fit_entry_allocator_unit
    import ffa_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_index[5:0], run_length[12:6], old_length[19:13], owner_tag[35:20]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]      s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_index[5:0], status[7:6]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int POS_W = ((IDX_W > LEN_W) ? IDX_W + 1 : LEN_W + 1) + 1;

    // Request fields
    logic [SIDX_W-1:0]   in_start;
    logic [LEN_W-1:0]    in_len;
    logic [LEN_W-1:0]    in_old;
    logic [TAG_BITS-1:0] in_tag;

    assign in_start = s_tdata[OFS_START +: SIDX_W];
    assign in_len   = s_tdata[OFS_LEN +: LEN_W];
    assign in_old   = s_tdata[OFS_OLD +: LEN_W];
    assign in_tag   = TAG_BITS'(s_tdata[OFS_TAG +: TAG_IN_W]);

    // Sequencer registers
    state_t              state_reg,  state_next;
    step_t               step_reg,   step_next;
    logic [SIDX_W-1:0]   start_reg,  start_next;
    logic [LEN_W-1:0]    len_reg,    len_next;
    logic [LEN_W-1:0]    old_reg,    old_next;
    logic [TAG_BITS-1:0] tag_reg,    tag_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [LEN_W-1:0]    cnt_reg,    cnt_next;
    logic [LEN_W-1:0]    run_reg,    run_next;
    logic                rd_v_reg,   rd_v_next;
    logic [POS_W-1:0]    rd_pos_reg, rd_pos_next;
    logic                wr_used_reg, wr_used_next;
    logic [SIDX_W-1:0]   idx_reg,    idx_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    // Output register
    logic                m_valid_reg,  m_valid_next;
    logic [SIDX_W-1:0]   m_idx_reg,    m_idx_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;

    // Configuration
    logic [LEN_W-1:0]    entries_reg;
    logic                cfg_wr;

    // Table interface
    logic                tbl_ready;
    logic                tbl_rd_en;
    logic                tbl_wr_en;
    logic [IDX_W-1:0]    tbl_addr;
    logic                tbl_rd_used;

    // Shared pass unit
    logic [POS_W-1:0]    entries_ext;
    logic [POS_W-1:0]    bound;
    logic                pos_in_bound;
    logic                cnt_zero;
    logic [POS_W-1:0]    pos_inc;
    logic [LEN_W-1:0]    cnt_dec;
    logic                fr_fail;
    logic                fr_ok;
    logic                fr_issue;
    logic [LEN_W-1:0]    run_inc;
    logic                fit_hit;
    logic                fit_issue;
    logic                fit_miss;
    logic [POS_W-1:0]    fit_at;
    logic                wr_go;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRIES_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_ENTRIES_IN_USE))
        begin
            entries_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? APB_DATA_W'(entries_reg) : '0;

    // Clamp the in-use bound to the table depth
    assign entries_ext = POS_W'(entries_reg);
    assign bound       = (entries_ext > POS_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                             : entries_ext;

    // Position counter, compare against the bound and remaining count
    assign pos_in_bound = pos_reg < bound;
    assign cnt_zero     = (cnt_reg == '0);
    assign pos_inc      = pos_reg + POS_W'(1);
    assign cnt_dec      = cnt_reg - LEN_W'(1);

    // Free-run check: a used entry or the bound ends it
    assign fr_fail  = (rd_v_reg && tbl_rd_used) || (!cnt_zero && !pos_in_bound);
    assign fr_ok    = !fr_fail && cnt_zero && !rd_v_reg;
    assign fr_issue = !fr_fail && !cnt_zero;

    // First-fit search: count free entries in a row
    assign run_inc   = run_reg + LEN_W'(1);
    assign fit_hit   = rd_v_reg && !tbl_rd_used && (run_inc == len_reg);
    assign fit_issue = !fit_hit && pos_in_bound;
    assign fit_miss  = !fit_hit && !pos_in_bound && !rd_v_reg;
    assign fit_at    = rd_pos_reg + POS_W'(1) - POS_W'(len_reg);

    // Run write: stop at the count or the bound
    assign wr_go = !cnt_zero && pos_in_bound;

    // Next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        old_next      = old_reg;
        tag_next      = tag_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        run_next      = run_reg;
        rd_v_next     = 1'b0;
        rd_pos_next   = rd_pos_reg;
        wr_used_next  = wr_used_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_idx_next    = m_idx_reg;
        m_status_next = m_status_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (tbl_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    start_next  = in_start;
                    len_next    = in_len;
                    old_next    = in_old;
                    tag_next    = in_tag;
                    step_next   = STEP_FINAL;
                    run_next    = '0;
                    idx_next    = in_start;
                    status_next = STAT_OK;
                    unique case (s_tuser)
                        REQ_FIND:
                        begin
                            idx_next = '0;
                            pos_next = '0;
                            if (in_len == '0)
                            begin
                                status_next = STAT_ZERO_LEN;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN_FIT;
                            end
                        end
                        REQ_CHECK:
                        begin
                            pos_next   = POS_W'(in_start);
                            cnt_next   = in_len;
                            state_next = ST_SCAN_FREE;
                        end
                        REQ_MARK:
                        begin
                            pos_next     = POS_W'(in_start);
                            cnt_next     = in_len;
                            wr_used_next = 1'b1;
                            state_next   = ST_WRITE;
                        end
                        REQ_CLEAR:
                        begin
                            pos_next     = POS_W'(in_start);
                            cnt_next     = in_len;
                            wr_used_next = 1'b0;
                            state_next   = ST_WRITE;
                        end
                        REQ_RESIZE:
                        begin
                            if (in_len == '0)
                            begin
                                status_next = STAT_ZERO_LEN;
                                state_next  = ST_DONE;
                            end
                            else if (in_len < in_old)
                            begin
                                // shrink: free the tail
                                pos_next     = POS_W'(in_start) + POS_W'(in_len);
                                cnt_next     = in_old - in_len;
                                wr_used_next = 1'b0;
                                state_next   = ST_WRITE;
                            end
                            else if (in_len > in_old)
                            begin
                                // grow: check the entries after the run
                                pos_next   = POS_W'(in_start) + POS_W'(in_old);
                                cnt_next   = in_len - in_old;
                                step_next  = STEP_GROW;
                                state_next = ST_SCAN_FREE;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            idx_next    = '0;
                            status_next = STAT_NO_SPACE;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN_FREE:
            begin
                if (fr_issue)
                begin
                    rd_v_next   = 1'b1;
                    rd_pos_next = pos_reg;
                    pos_next    = pos_inc;
                    cnt_next    = cnt_dec;
                end
                if (fr_fail || fr_ok)
                begin
                    if (step_reg == STEP_GROW)
                    begin
                        if (fr_ok)
                        begin
                            // grow in place
                            pos_next     = POS_W'(start_reg) + POS_W'(old_reg);
                            cnt_next     = len_reg - old_reg;
                            wr_used_next = 1'b1;
                            step_next    = STEP_FINAL;
                        end
                        else
                        begin
                            // free the old run before searching
                            pos_next     = POS_W'(start_reg);
                            cnt_next     = old_reg;
                            wr_used_next = 1'b0;
                            step_next    = STEP_MOVE_FREE;
                        end
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        status_next = fr_fail ? STAT_NO_SPACE : STAT_OK;
                        state_next  = ST_DONE;
                    end
                end
            end

            ST_SCAN_FIT:
            begin
                if (fit_issue)
                begin
                    rd_v_next   = 1'b1;
                    rd_pos_next = pos_reg;
                    pos_next    = pos_inc;
                end
                if (rd_v_reg)
                begin
                    run_next = tbl_rd_used ? '0 : run_inc;
                end
                if (fit_hit)
                begin
                    idx_next = fit_at[SIDX_W-1:0];
                    if (step_reg == STEP_MOVE_FIT)
                    begin
                        // place the run at its new home
                        pos_next     = fit_at;
                        cnt_next     = len_reg;
                        wr_used_next = 1'b1;
                        step_next    = STEP_FINAL;
                        state_next   = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (fit_miss)
                begin
                    status_next = STAT_NO_SPACE;
                    if (step_reg == STEP_MOVE_FIT)
                    begin
                        // restore the old run
                        pos_next     = POS_W'(start_reg);
                        cnt_next     = old_reg;
                        wr_used_next = 1'b1;
                        step_next    = STEP_FINAL;
                        state_next   = ST_WRITE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_WRITE:
            begin
                if (wr_go)
                begin
                    pos_next = pos_inc;
                    cnt_next = cnt_dec;
                end
                else if (step_reg == STEP_MOVE_FREE)
                begin
                    pos_next   = '0;
                    run_next   = '0;
                    step_next  = STEP_MOVE_FIT;
                    state_next = ST_SCAN_FIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // hand the result over once the output slot is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_idx_next    = idx_reg;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        tbl_rd_en = ((state_reg == ST_SCAN_FREE) && fr_issue) ||
                    ((state_reg == ST_SCAN_FIT) && fit_issue);
        tbl_wr_en = (state_reg == ST_WRITE) && wr_go;
        tbl_addr  = pos_reg[IDX_W-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            step_reg    <= STEP_FINAL;
            rd_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            rd_v_reg    <= rd_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        len_reg      <= len_next;
        old_reg      <= old_next;
        tag_reg      <= tag_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        run_reg      <= run_next;
        rd_pos_reg   <= rd_pos_next;
        wr_used_reg  <= wr_used_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        m_idx_reg    <= m_idx_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_status_reg, m_idx_reg};

    ffa_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (tbl_ready),
        .rd_en   (tbl_rd_en),
        .wr_en   (tbl_wr_en),
        .addr    (tbl_addr),
        .wr_used (wr_used_reg),
        .wr_tag  (tag_reg),
        .rd_used (tbl_rd_used)
    );

endmodule

// ----- rtl/ffa_checker.sv -----
// Port-level checks for the first-fit entry allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_entry_allocator_unit.
`timescale 1ns / 1ps

module ffa_checker
    import ffa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A result leaves only through a transaction
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without a transaction");

    // One request at a time: the block is busy after taking one
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // Status is one of the defined codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1 -: STAT_W] == STAT_OK) ||
                     (m_tdata[M_TDATA_W-1 -: STAT_W] == STAT_ZERO_LEN) ||
                     (m_tdata[M_TDATA_W-1 -: STAT_W] == STAT_NO_SPACE))
        else $error("undefined status code");

endmodule

bind first_fit_entry_allocator_unit ffa_checker u_ffa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/tb_first_fit_entry_allocator_unit.sv -----
// Self-checking testbench for first_fit_entry_allocator_unit. Directed and random
// requests go in, and each result is checked against a table predictor kept here.
// Depends on ffa_pkg and the block RTL; both stream sides are paced at random.
`timescale 1ns / 1ps

module tb_first_fit_entry_allocator_unit;
    import ffa_pkg::*;

    localparam int CLK_HALF_NS   = 4;
    localparam int DEPTH         = DEF_TABLE_DEPTH;
    localparam int RX_HOLD_CYCLES = 400;
    // Longest request: a moving resize
    localparam int DRAIN_CYCLES  = 300;
    localparam int MAX_REPORTS   = 50;
    localparam logic [APB_ADDR_W-1:0] ENTRIES_ADDR = {REG_ENTRIES_IN_USE, 2'b00};

    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [SIDX_W-1:0]   start;
        logic [LEN_W-1:0]    len;
        logic [LEN_W-1:0]    old_len;
        logic [TAG_IN_W-1:0] tag;
    } alloc_req_t;

    typedef struct packed {
        logic [SIDX_W-1:0] idx;
        logic [STAT_W-1:0] st;
    } alloc_res_t;

    // DUT signals, all inputs known from time zero
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // start_index[5:0], run_length[12:6], old_length[19:13], owner_tag[35:20]
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // req_type[2:0]
    logic [REQ_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // result_index[5:0], status[7:6]
    logic [M_TDATA_W-1:0]  m_tdata;

    // Predictor state: used flags and the in-use register
    logic [DEPTH-1:0] model_used;
    logic [LEN_W-1:0] model_entries;

    alloc_res_t pending_results[$];
    int         live_start[$];
    int         live_len[$];

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int kind_count[8];
    int status_count[4];
    int tx_burst_left = 0;
    bit tx_steady     = 1'b0;
    bit rx_hold_req   = 1'b0;

    first_fit_entry_allocator_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic int managed_bound();
        return (model_entries > DEPTH) ? DEPTH : int'(model_entries);
    endfunction

    function automatic bit slot_free(input int i);
        return (i < managed_bound()) && !model_used[i];
    endfunction

    function automatic bit span_free(input int from, input int len);
        for (int k = 0; k < len; k++)
        begin
            if (!slot_free(from + k))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Lowest start of len free entries inside the bound
    function automatic bit find_fit(input int len, output int at);
        int run;
        run = 0;
        at  = 0;
        if (len == 0)
            return 1'b0;
        for (int i = 0; i < managed_bound(); i++)
        begin
            if (!model_used[i])
            begin
                run++;
                if (run == len)
                begin
                    at = i + 1 - len;
                    return 1'b1;
                end
            end
            else
                run = 0;
        end
        return 1'b0;
    endfunction

    // Drop writes at or beyond the bound
    function automatic void write_span(input int from, input int len, input bit used_val);
        for (int k = 0; k < len; k++)
        begin
            if (from + k >= managed_bound())
                break;
            model_used[from + k] = used_val;
        end
    endfunction

    function automatic alloc_res_t predict_allocation(input alloc_req_t rq);
        alloc_res_t rs;
        int start, len, old, at;
        start  = rq.start;
        len    = rq.len;
        old    = rq.old_len;
        rs.idx = '0;
        rs.st  = STAT_OK;
        case (rq.kind)
            REQ_FIND:
            begin
                if (len == 0)
                    rs.st = STAT_ZERO_LEN;
                else if (find_fit(len, at))
                    rs.idx = at[SIDX_W-1:0];
                else
                    rs.st = STAT_NO_SPACE;
            end
            REQ_CHECK:
            begin
                rs.idx = rq.start;
                rs.st  = span_free(start, len) ? STAT_OK : STAT_NO_SPACE;
            end
            REQ_MARK:
            begin
                rs.idx = rq.start;
                write_span(start, len, 1'b1);
            end
            REQ_CLEAR:
            begin
                rs.idx = rq.start;
                write_span(start, len, 1'b0);
            end
            REQ_RESIZE:
            begin
                rs.idx = rq.start;
                if (len == 0)
                    rs.st = STAT_ZERO_LEN;
                else if (len < old)
                    write_span(start + len, old - len, 1'b0);
                else if (len > old)
                begin
                    if (span_free(start + old, len - old))
                        write_span(start + old, len - old, 1'b1);
                    else
                    begin
                        // Free the run, try to move it, restore on failure
                        write_span(start, old, 1'b0);
                        if (find_fit(len, at))
                        begin
                            write_span(at, len, 1'b1);
                            rs.idx = at[SIDX_W-1:0];
                        end
                        else
                        begin
                            write_span(start, old, 1'b1);
                            rs.st = STAT_NO_SPACE;
                        end
                    end
                end
            end
            default:
                rs.st = STAT_NO_SPACE;
        endcase
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    function automatic alloc_req_t make_req(input logic [REQ_W-1:0] kind, input int start,
                                            input int len, input int old, input int tag);
        alloc_req_t rq;
        rq.kind    = kind;
        rq.start   = start[SIDX_W-1:0];
        rq.len     = len[LEN_W-1:0];
        rq.old_len = old[LEN_W-1:0];
        rq.tag     = tag[TAG_IN_W-1:0];
        return rq;
    endfunction

    // Mostly short runs, now and then long ones
    function automatic int pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 8);
        else if (roll < 95)
            return $urandom_range(9, 32);
        return $urandom_range(33, DEPTH);
    endfunction

    // Offer one request, wait for the transaction, then log its expected result
    task automatic send_req(input alloc_req_t rq, output alloc_res_t rs);
        logic [S_TDATA_W-1:0] word;
        int gap;
        if (tx_burst_left == 0)
        begin
            gap = (tx_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tx_burst_left = $urandom_range(1, 16);
        end
        tx_burst_left--;
        word = '0;
        word[OFS_START +: SIDX_W]  = rq.start;
        word[OFS_LEN   +: LEN_W]   = rq.len;
        word[OFS_OLD   +: LEN_W]   = rq.old_len;
        word[OFS_TAG   +: TAG_IN_W] = rq.tag;
        s_tdata  <= word;
        s_tuser  <= rq.kind;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        rs = predict_allocation(rq);
        pending_results.push_back(rs);
        kind_count[rq.kind]++;
        items_sent++;
    endtask

    // Stop offering, let every result drain, then let the block settle
    task automatic wait_block_idle(input int settle);
        s_tvalid <= 1'b0;
        tx_burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_entries_in_use(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENTRIES_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_entries = value[LEN_W-1:0];
    endtask

    task automatic free_live_run(input int j);
        alloc_res_t rs;
        send_req(make_req(REQ_CLEAR, live_start[j], live_len[j], $urandom_range(0, DEPTH),
                          $urandom), rs);
        live_start.delete(j);
        live_len.delete(j);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        alloc_res_t rs;
        // Find and check: zero length, whole table, then a full table
        send_req(make_req(REQ_FIND,   0,  0,  0, 16'h0000), rs);
        send_req(make_req(REQ_FIND,  63, 64, 64, 16'hFFFF), rs);
        send_req(make_req(REQ_CHECK,  0,  0,  0, 16'h0000), rs);
        send_req(make_req(REQ_CHECK,  0, 64,  0, 16'h0000), rs);
        send_req(make_req(REQ_CHECK, 63, 64, 64, 16'hFFFF), rs);
        send_req(make_req(REQ_MARK,   0, 64,  0, 16'hFFFF), rs);
        send_req(make_req(REQ_FIND,   0,  1,  0, 16'h0000), rs);
        send_req(make_req(REQ_CHECK, 63,  1,  0, 16'h0000), rs);
        // Clear: zero length does nothing, then wipe everything
        send_req(make_req(REQ_CLEAR,  0,  0,  0, 16'h0000), rs);
        send_req(make_req(REQ_CLEAR,  0, 64,  0, 16'h0000), rs);
        // Mark running past the end of the table
        send_req(make_req(REQ_MARK,  60, 10,  0, 16'h0000), rs);
        send_req(make_req(REQ_CHECK, 63,  2,  0, 16'h0000), rs);
        send_req(make_req(REQ_CLEAR, 60,  4,  0, 16'h0000), rs);
        send_req(make_req(REQ_CHECK, 62,  2,  0, 16'h0000), rs);
        // Resize: zero length, shrink, grow in place, move, failed move, same size
        send_req(make_req(REQ_MARK,    0,  4,  0, 16'h1234), rs);
        send_req(make_req(REQ_RESIZE,  0,  0,  4, 16'h1234), rs);
        send_req(make_req(REQ_RESIZE,  0,  2,  4, 16'h1234), rs);
        send_req(make_req(REQ_RESIZE,  0,  6,  2, 16'h1234), rs);
        send_req(make_req(REQ_MARK,    8,  2,  0, 16'hAAAA), rs);
        send_req(make_req(REQ_RESIZE,  0, 10,  6, 16'h1234), rs);
        send_req(make_req(REQ_RESIZE, rs.idx, 64, 10, 16'h5555), rs);
        send_req(make_req(REQ_RESIZE,  8,  2,  2, 16'hAAAA), rs);
        // Unknown request types
        send_req(make_req(3'd5, $urandom, 64, 64, $urandom), rs);
        send_req(make_req(3'd6, $urandom, $urandom_range(0, 64), 0, $urandom), rs);
        send_req(make_req(3'd7, 0, 0, $urandom_range(0, 64), 16'h0000), rs);
        send_req(make_req(REQ_CLEAR,  0, 64,  0, 16'h0000), rs);
    endtask

    // Allocation traffic with random content, plus some noise
    task automatic test_random_traffic(input int n_items);
        alloc_res_t rs;
        int stop_at, roll, j, ln, tag;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 28)
            begin
                // Allocate: find a run, then mark it
                ln  = pick_len();
                tag = $urandom;
                send_req(make_req(REQ_FIND, $urandom, ln, $urandom_range(0, DEPTH), tag), rs);
                if (rs.st == STAT_OK)
                begin
                    send_req(make_req(REQ_MARK, rs.idx, ln, $urandom_range(0, DEPTH), tag), rs);
                    live_start.push_back(rs.idx);
                    live_len.push_back(ln);
                end
                else if (live_start.size() > 0)
                    free_live_run($urandom_range(0, live_start.size() - 1));
            end
            else if (roll < 48 && live_start.size() > 0)
            begin
                j  = $urandom_range(0, live_start.size() - 1);
                ln = ($urandom_range(0, 9) == 0) ? 0 : pick_len();
                send_req(make_req(REQ_RESIZE, live_start[j], ln, live_len[j], $urandom), rs);
                if (rs.st == STAT_OK)
                begin
                    live_start[j] = rs.idx;
                    live_len[j]   = ln;
                end
            end
            else if (roll < 60 && live_start.size() > 0)
                free_live_run($urandom_range(0, live_start.size() - 1));
            else if (roll < 70)
                send_req(make_req(REQ_CHECK, $urandom, ($urandom_range(0, 15) == 0) ? 0 :
                                  pick_len(), $urandom_range(0, DEPTH), $urandom), rs);
            else
                send_req(make_req(REQ_W'($urandom_range(0, 7)), $urandom,
                                  $urandom_range(0, DEPTH), $urandom_range(0, DEPTH),
                                  $urandom), rs);
        end
    endtask

    // Change the in-use bound on an idle block and start from a clean table
    task automatic test_bound_setting(input int entries, input int n_items);
        alloc_res_t rs;
        wait_block_idle(DRAIN_CYCLES);
        write_entries_in_use(entries);
        live_start.delete();
        live_len.delete();
        send_req(make_req(REQ_CLEAR, 0, DEPTH, 0, 0), rs);
        send_req(make_req(REQ_FIND, 0, 1, 0, 0), rs);
        send_req(make_req(REQ_CHECK, (entries > 0) ? ((entries - 1) % DEPTH) : 0, 2, 0, 0), rs);
        test_random_traffic(n_items);
    endtask

    // Hold the result side off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        alloc_res_t rs;
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
        for (int k = 0; k < 24; k++)
            send_req(make_req(REQ_W'($urandom_range(0, 4)), $urandom, $urandom_range(0, 8),
                              $urandom_range(0, 8), $urandom), rs);
        while (rx_hold_req)
            @(posedge clk);
        tx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------
    initial
    begin : rx_pacing
        int mode, left, hold_cnt, phase;
        mode  = 0;
        left  = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                m_tready    <= 1'b1;
                rx_hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 128);
                end
                left--;
                phase++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (phase % 5 < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        alloc_res_t want;
        logic [SIDX_W-1:0] got_idx;
        logic [STAT_W-1:0] got_st;
        if (m_tvalid === 1'b1 && m_tready)
        begin
            got_idx = m_tdata[SIDX_W-1:0];
            got_st  = m_tdata[SIDX_W +: STAT_W];
            results_seen++;
            status_count[got_st]++;
            if (pending_results.size() == 0)
                report_mismatch("result with no pending request", m_tdata, 0);
            else
            begin
                want = pending_results.pop_front();
                if (got_idx !== want.idx)
                    report_mismatch("result_index", got_idx, want.idx);
                if (got_st !== want.st)
                    report_mismatch("status", got_st, want.st);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial
    begin
        model_used    = '0;
        model_entries = ENTRIES_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rewrite the reset value while the clearing pass runs
        write_entries_in_use(DEPTH);
        test_directed();
        test_random_traffic(350);
        test_bound_setting(1, 40);
        test_bound_setting(0, 20);
        test_bound_setting(127, 120);
        test_bound_setting(37, 140);
        test_backpressure();
        test_bound_setting(DEPTH, 120);

        wait_block_idle(DRAIN_CYCLES);
        $display("Covered %0d requests: find %0d, check %0d, mark %0d, clear %0d, resize %0d, other %0d",
                 items_sent, kind_count[REQ_FIND], kind_count[REQ_CHECK], kind_count[REQ_MARK],
                 kind_count[REQ_CLEAR], kind_count[REQ_RESIZE],
                 kind_count[5] + kind_count[6] + kind_count[7]);
        $display("Checked %0d results (ok %0d, zero length %0d, no space %0d), %0d errors",
                 results_seen, status_count[STAT_OK], status_count[STAT_ZERO_LEN],
                 status_count[STAT_NO_SPACE], error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #12_000_000;
        $display("Run did not finish in time, %0d results still pending",
                 pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ffa_pkg.sv
rtl/ffa_table.sv
rtl/first_fit_entry_allocator_unit.sv
rtl/ffa_checker.sv
dv/tb_first_fit_entry_allocator_unit.sv
